// File: design/value_noise_fbm_generator_core_assert.svh
// Assertion macros used by the checker file.
`ifndef VALUE_NOISE_FBM_GENERATOR_CORE_ASSERT_SVH
`define VALUE_NOISE_FBM_GENERATOR_CORE_ASSERT_SVH

// a holds, then b holds after the delay given as argument n
`define VNF_ASSERT_DELAY(lbl, clk, rst_n, a, n, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("lbl failed");

// a holds, then b holds in the next cycle
`define VNF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");

`endif

// File: design/vnf_pkg.sv
package vnf_pkg;

    localparam logic [1:0] REG_SEED   = 2'd0;
    localparam logic [1:0] REG_COUNT  = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic [31:0] SEED_RESET  = 32'd0;
    localparam logic [3:0]  COUNT_RESET = 4'd3;
    localparam logic [23:0] SCALE_RESET = 24'd559241;

    localparam logic [31:0] SEED_MIX  = 32'h5bd1e995;
    localparam int          SEED_STEP = 101;
    localparam logic [31:0] HASH_K1   = 32'h7feb352d;
    localparam logic [31:0] HASH_K2   = 32'h846ca68b;
    localparam logic [31:0] PRIME_X   = 32'd73856093;
    localparam logic [31:0] PRIME_Z   = 32'd19349663;

    // octave stages: lattice, hash, blend
    localparam int OCT_LAT  = 10;
    // scale, octave, sum, normalize
    localparam int PIPE_LAT = 15;

    typedef logic [31:0] freq_t;
    typedef logic [25:0] recip_t;

    // 2.03^i in Q8.24
    localparam freq_t FREQ_TABLE [8] = '{
        32'd16777216, 32'd34057748, 32'd69137229, 32'd140348576,
        32'd284907609, 32'd578362446, 32'd1174075765, 32'd2383373802
    };

    // 2^24 * 2^n / (2^n - 1)
    localparam recip_t RECIP_TABLE [8] = '{
        26'd33554432, 26'd22369621, 26'd19173961, 26'd17895697,
        26'd17318416, 26'd17043521, 26'd16909320, 26'd16843009
    };

endpackage

// File: design/vnf_corner.sv
module vnf_corner
(
    input  logic        clk,
    input  logic [31:0] xi,
    input  logic [31:0] zi,
    input  logic [31:0] seed,
    output logic [23:0] h
);
    import vnf_pkg::*;

    logic [31:0] pa_reg, pb_reg, pb_d1_reg, pb_d2_reg;
    logic [31:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic [23:0] h_reg;
    logic [31:0] pa_next, pb_next, v1_next, v2_next, v3_next, b_mix;
    logic [23:0] h_next;

    always_comb
    begin
        pa_next = (xi * PRIME_X) ^ seed;
        pb_next = zi * PRIME_Z;
        v1_next = (pa_reg ^ (pa_reg >> 16)) * HASH_K1;
        v2_next = (v1_reg ^ (v1_reg >> 15)) * HASH_K2;
        b_mix   = (v2_reg ^ (v2_reg >> 16)) ^ pb_d2_reg;
        v3_next = (b_mix ^ (b_mix >> 16)) * HASH_K1;
        h_next  = 24'(v4_reg ^ (v4_reg >> 16));
    end

    always_ff @(posedge clk)
    begin
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        v1_reg    <= v1_next;
        pb_d1_reg <= pb_reg;
        v2_reg    <= v2_next;
        pb_d2_reg <= pb_d1_reg;
        v3_reg    <= v3_next;
        v4_reg    <= (v3_reg ^ (v3_reg >> 15)) * HASH_K2;
        h_reg     <= h_next;
    end

    assign h = h_reg;

endmodule

// File: design/vnf_octave.sv
module vnf_octave
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic signed [31:0] sx,
    input  logic signed [31:0] sz,
    input  logic [31:0]        freq,
    input  logic [31:0]        seed,
    output logic [23:0]        value
);
    import vnf_pkg::*;

    localparam int F = FRACTION_BITS;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic signed [64:0] px_reg, pz_reg;
    logic [71:0] pxe, pze;
    logic [31:0] xi_reg, xi1_reg, zi_reg, zi1_reg;
    logic [F-1:0] tx_reg, tz_reg, t2x_reg, t2z_reg;
    logic [F+1:0] mx_reg, mz_reg;
    logic [F:0] wx_reg [5];
    logic [F:0] wz_reg [6];
    logic [23:0] ha, hb, hc, hd;
    logic [23:0] ab_reg, cd_reg, val_reg;
    logic [23:0] ab_next, cd_next, val_next;

    always_comb
    begin
        pxe = {{7{px_reg[64]}}, px_reg};
        pze = {{7{pz_reg[64]}}, pz_reg};
        ab_next = 24'(((F+25)'(ha) * (F+25)'(ONE - wx_reg[4])
                     + (F+25)'(hb) * (F+25)'(wx_reg[4])) >> F);
        cd_next = 24'(((F+25)'(hc) * (F+25)'(ONE - wx_reg[4])
                     + (F+25)'(hd) * (F+25)'(wx_reg[4])) >> F);
        val_next = 24'(((F+25)'(ab_reg) * (F+25)'(ONE - wz_reg[5])
                      + (F+25)'(cd_reg) * (F+25)'(wz_reg[5])) >> F);
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= 65'(sx) * 65'($signed({1'b0, freq}));
        pz_reg  <= 65'(sz) * 65'($signed({1'b0, freq}));
        // cell is the integer part mod 2^32, t the fraction
        xi_reg  <= pxe[71:40];
        xi1_reg <= pxe[71:40] + 32'd1;
        zi_reg  <= pze[71:40];
        zi1_reg <= pze[71:40] + 32'd1;
        tx_reg  <= pxe[39:40-F];
        tz_reg  <= pze[39:40-F];
        // smoothstep
        t2x_reg <= F'(((2*F)'(tx_reg) * (2*F)'(tx_reg)) >> F);
        t2z_reg <= F'(((2*F)'(tz_reg) * (2*F)'(tz_reg)) >> F);
        mx_reg  <= (F+2)'(3) * (F+2)'(ONE) - (F+2)'({tx_reg, 1'b0});
        mz_reg  <= (F+2)'(3) * (F+2)'(ONE) - (F+2)'({tz_reg, 1'b0});
        wx_reg[0] <= (F+1)'(((2*F+2)'(t2x_reg) * (2*F+2)'(mx_reg)) >> F);
        wz_reg[0] <= (F+1)'(((2*F+2)'(t2z_reg) * (2*F+2)'(mz_reg)) >> F);
        for (int k = 1; k < 5; k++)
        begin
            wx_reg[k] <= wx_reg[k-1];
        end
        for (int k = 1; k < 6; k++)
        begin
            wz_reg[k] <= wz_reg[k-1];
        end
        ab_reg  <= ab_next;
        cd_reg  <= cd_next;
        val_reg <= val_next;
    end

    vnf_corner u_ca (.clk(clk), .xi(xi_reg),  .zi(zi_reg),  .seed(seed), .h(ha));
    vnf_corner u_cb (.clk(clk), .xi(xi1_reg), .zi(zi_reg),  .seed(seed), .h(hb));
    vnf_corner u_cc (.clk(clk), .xi(xi_reg),  .zi(zi1_reg), .seed(seed), .h(hc));
    vnf_corner u_cd (.clk(clk), .xi(xi1_reg), .zi(zi1_reg), .seed(seed), .h(hd));

    assign value = val_reg;

endmodule

// File: design/value_noise_fbm_generator_core.sv
// Fractal value noise, octaves fully unrolled, one sample per clock while
// busy is low. done pulses for each accepted start word once it has passed
// the scale, lattice, corner hash, blend, octave sum and normalize stages.
// Throughput: one word per cycle; busy is low except during reset and the
// cycle after it. The receiver cannot stall, so nothing waits on the output.
// Reset (rst_n low, async) clears valid bits and loads register defaults.
module value_noise_fbm_generator_core
#(
    parameter int MAX_OCTAVES   = 8,
    parameter int FRACTION_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] z_coord,
    output logic               done,
    output logic [15:0]        noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import vnf_pkg::*;

    // configuration registers: user writes only while pipe is empty (unenforced)
    logic [31:0] seed_reg;
    logic [3:0]  count_reg;
    logic [23:0] scale_reg;
    logic        busy_reg;
    logic [PIPE_LAT-1:0] vld_reg, vld_next;
    logic        accept;

    // scaled point, Q16.16
    logic signed [56:0] ex_full, ez_full;
    logic signed [31:0] sx_reg, sz_reg;

    logic [31:0] seed_base;
    logic [23:0] oct_val [MAX_OCTAVES];
    logic [23:0] term [MAX_OCTAVES];
    logic [3:0]  n_eff;
    logic [23:0] sum_e_next, sum_o_next;
    logic [23:0] sum_e_reg, sum_o_reg, sum_reg;
    logic [49:0] prod_reg;
    logic [15:0] noise_reg;

    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy_reg;
    assign busy      = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= SEED_RESET;
            count_reg <= COUNT_RESET;
            scale_reg <= SCALE_RESET;
            busy_reg  <= 1'b1;
            vld_reg   <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= vld_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SEED:  seed_reg  <= cfg_data;
                    REG_COUNT: count_reg <= cfg_data[3:0];
                    REG_SCALE: scale_reg <= cfg_data[23:0];
                    default:   ;
                endcase
            end
        end
    end

    // valid bit rides along each stage
    assign vld_next = {vld_reg[PIPE_LAT-2:0], accept};

    always_comb
    begin
        ex_full = 57'(x_coord) * 57'($signed({1'b0, scale_reg}));
        ez_full = 57'(z_coord) * 57'($signed({1'b0, scale_reg}));
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= ex_full[55:24];
        sz_reg <= ez_full[55:24];
    end

    assign seed_base = seed_reg ^ SEED_MIX;

    // one octave engine per frequency
    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        vnf_octave #(.FRACTION_BITS(FRACTION_BITS)) u_oct
        (
            .clk   (clk),
            .sx    (sx_reg),
            .sz    (sz_reg),
            .freq  (FREQ_TABLE[i]),
            .seed  (seed_base + 32'(i * SEED_STEP)),
            .value (oct_val[i])
        );
    end

    // count zero means one octave; clamp to the octaves built
    always_comb
    begin
        if (count_reg == 4'd0)
            n_eff = 4'd1;
        else if (count_reg > 4'(MAX_OCTAVES))
            n_eff = 4'(MAX_OCTAVES);
        else
            n_eff = count_reg;
    end

    // amplitude 2^-(i+1), unused octaves drop out
    always_comb
    begin
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            term[i] = (4'(i) < n_eff) ? 24'(oct_val[i] >> (i + 1)) : 24'd0;
        end
        sum_e_next = '0;
        sum_o_next = '0;
        for (int i = 0; i < MAX_OCTAVES; i += 2)
        begin
            sum_e_next = sum_e_next + term[i];
        end
        for (int i = 1; i < MAX_OCTAVES; i += 2)
        begin
            sum_o_next = sum_o_next + term[i];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_e_reg <= sum_e_next;
        sum_o_reg <= sum_o_next;
        sum_reg   <= sum_e_reg + sum_o_reg;
        prod_reg  <= 50'(sum_reg) * 50'(RECIP_TABLE[3'(n_eff - 4'd1)]);
        noise_reg <= (prod_reg[49:48] != 2'b00) ? 16'hffff : prod_reg[47:32];
    end

    assign done        = vld_reg[PIPE_LAT-1];
    assign noise_value = noise_reg;

endmodule

// File: design/vnf_checker.sv
module vnf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        cfg_valid,
    input logic        cfg_ready
);
    import vnf_pkg::*;
    `include "value_noise_fbm_generator_core_assert.svh"

    logic acc;
    assign acc = start && !busy;

    // every accepted word comes out after the fixed latency
    `VNF_ASSERT_DELAY(a_lat_out, clk, rst_n, acc, PIPE_LAT, done)
    // no result without a matching accept
    `VNF_ASSERT_DELAY(a_no_ghost, clk, rst_n, done, 0, $past(acc, PIPE_LAT))
    // once running the core keeps taking words
    `VNF_ASSERT_NEXT(a_busy_low, clk, rst_n, !busy, !busy)
    // config channel never back-pressures
    `VNF_ASSERT_NEXT(a_cfg_rdy, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind value_noise_fbm_generator_core vnf_checker u_vnf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// File: tb/tb_value_noise_fbm_generator_core.sv
`timescale 1ns / 100ps

// Fractal value-noise core: directed table of coordinates and register
// settings, then bursts of random coordinates across several register
// settings. Every noise word is checked against a behavioral predictor.
module tb_value_noise_fbm_generator_core;
    import vnf_pkg::*;

    localparam int RANDOM_WORDS = 1150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = PIPE_LAT + 10;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] x_coord;
    logic signed [31:0] z_coord;
    logic               done;
    logic [15:0]        noise_value;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    value_noise_fbm_generator_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_coord     (x_coord),
        .z_coord     (z_coord),
        .done        (done),
        .noise_value (noise_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Predictor's shadow copy of the registers
    logic [31:0] shadow_seed;
    logic [3:0]  shadow_count;
    logic [23:0] shadow_scale;

    logic [15:0] expected_noise [$];
    int          error_count;
    int          words_sent;
    int          words_checked;
    int          idle_cycles;

    // Directed table: coordinates with optional hand-read expectation
    typedef struct {
        logic [31:0] x;
        logic [31:0] z;
        logic        has_value;
        logic [15:0] value;
    } coord_row_t;

    function automatic longint floor_sr(longint v, int k);
        return v >>> k;   // arithmetic shift is floor for signed values
    endfunction

    function automatic logic [31:0] avalanche(logic [31:0] v);
        v = v ^ (v >> 16);
        v = v * HASH_K1;
        v = v ^ (v >> 15);
        v = v * HASH_K2;
        v = v ^ (v >> 16);
        return v;
    endfunction

    function automatic logic [63:0] corner_value(logic [31:0] seed, logic [31:0] xi,
                                                 logic [31:0] zi);
        logic [31:0] a;
        logic [31:0] b;
        a = (xi * PRIME_X) ^ seed;
        b = avalanche(a) ^ (zi * PRIME_Z);
        return {40'd0, avalanche(b) & 32'h00ffffff};
    endfunction

    function automatic logic [63:0] mix_lerp(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] w);
        return (a * (64'd65536 - w) + b * w) >> 16;
    endfunction

    function automatic logic [63:0] fade(logic [63:0] t);
        logic [63:0] t2;
        t2 = (t * t) >> 16;
        return (t2 * ((64'd3 << 16) - 2 * t)) >> 16;
    endfunction

    // Noise word for one point under the shadow registers
    function automatic logic [15:0] fbm_noise(logic [31:0] xw, logic [31:0] zw);
        longint      sx;
        longint      sz;
        longint      cx;
        longint      cz;
        logic [31:0] base;
        logic [31:0] seed;
        logic [31:0] xi;
        logic [31:0] zi;
        logic [63:0] wx;
        logic [63:0] wz;
        logic [63:0] sum;
        logic [63:0] oct;
        logic [127:0] r;
        int          n;
        sx = floor_sr(longint'($signed(xw)) * longint'(shadow_scale), 24);
        sz = floor_sr(longint'($signed(zw)) * longint'(shadow_scale), 24);
        base = shadow_seed ^ SEED_MIX;
        n = shadow_count;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            seed = base + i * SEED_STEP;
            // s is at most ~2^31 and freq below 2^32: product fits in 64 bits,
            // so use 128-bit signed math
            cx = longint'((128'(signed'(sx)) * $signed({96'd0, FREQ_TABLE[i]})) >>> 24);
            cz = longint'((128'(signed'(sz)) * $signed({96'd0, FREQ_TABLE[i]})) >>> 24);
            xi = cx[47:16];
            zi = cz[47:16];
            wx = fade({48'd0, cx[15:0]});
            wz = fade({48'd0, cz[15:0]});
            oct = mix_lerp(mix_lerp(corner_value(seed, xi, zi),
                                    corner_value(seed, xi + 1, zi), wx),
                           mix_lerp(corner_value(seed, xi, zi + 1),
                                    corner_value(seed, xi + 1, zi + 1), wx), wz);
            sum += oct >> (i + 1);
        end
        r = (128'(sum) * 128'(RECIP_TABLE[n - 1])) >> 32;
        if (r > 65535) r = 65535;
        return r[15:0];
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("MISMATCH %s: noise_value got %0d want %0d at %0t",
                 what, got, want, $realtime);
        error_count++;
    endtask

    // Result side: done is sampled at each rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_noise.size() == 0)
                report_mismatch("unexpected word", noise_value, 16'd0);
            else
            begin
                logic [15:0] want;
                want = expected_noise.pop_front();
                if (noise_value !== want)
                    report_mismatch("noise word", noise_value, want);
                words_checked++;
            end
        end
    end

    // Watchdog: cycles in which nothing is accepted or completed
    always @(posedge clk)
    begin
        if ((start && !busy) || (cfg_valid && cfg_ready) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Register write through the config channel; only called when idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SEED:  shadow_seed  = data;
            REG_COUNT: shadow_count = data[3:0];
            REG_SCALE: shadow_scale = data[23:0];
            default: ;  // unknown index ignored
        endcase
        @(posedge clk);
    endtask

    // Send one coordinate word; hold start through back-to-back words
    task automatic send_word(logic [31:0] xw, logic [31:0] zw, logic has_value,
                             logic [15:0] value, logic keep_start);
        logic [15:0] pred;
        start   <= 1'b1;
        x_coord <= xw;
        z_coord <= zw;
        do @(posedge clk); while (busy);
        pred = fbm_noise(xw, zw);
        if (has_value && pred !== value)
            report_mismatch("predictor vs table", pred, value);
        expected_noise.push_back(pred);
        words_sent++;
        if (!keep_start)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        while (expected_noise.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Bursts of random coordinates with random gaps between bursts
    task automatic random_phase(int count);
        int left;
        int burst;
        logic [31:0] xw;
        logic [31:0] zw;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 3))
                    0: begin xw = $urandom; zw = $urandom; end
                    // modest world range, where the default scale lives
                    1: begin
                        xw = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
                        zw = $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
                    end
                    2: begin
                        xw = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
                        zw = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
                    end
                    default: begin
                        xw = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                                  : 32'h80000000 + $urandom_range(0, 255);
                        zw = $urandom;
                    end
                endcase
                send_word(xw, zw, 1'b0, 16'd0, k != burst - 1);
            end
            left -= burst;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    coord_row_t directed [] = '{
        '{32'h00000000, 32'h00000000, 1'b0, 16'd0},
        '{32'h7fffffff, 32'h7fffffff, 1'b0, 16'd0},
        '{32'h80000000, 32'h80000000, 1'b0, 16'd0},
        '{32'h7fffffff, 32'h80000000, 1'b0, 16'd0},
        '{32'h80000000, 32'h7fffffff, 1'b0, 16'd0},
        '{32'hffffffff, 32'h00000001, 1'b0, 16'd0},
        '{32'h00010000, 32'hffff0000, 1'b0, 16'd0},
        '{32'h001e0000, 32'h001e0000, 1'b0, 16'd0},
        '{32'hffe20000, 32'h00078000, 1'b0, 16'd0},
        '{32'h55555555, 32'haaaaaaaa, 1'b0, 16'd0},
        '{32'haaaaaaaa, 32'h55555555, 1'b0, 16'd0},
        '{32'h12345678, 32'h9abcdef0, 1'b0, 16'd0}
    };

    // Register settings walked through: seed, count, scale
    logic [31:0] seed_set  [6] = '{32'd0, 32'hffffffff, 32'h5bd1e995, 32'h0, 32'hdeadbeef, 32'h1};
    logic [31:0] count_set [6] = '{32'd1, 32'd8, 32'd0, 32'd15, 32'd5, 32'd3};
    logic [31:0] scale_set [6] = '{32'd1, 32'h00ffffff, 32'd0, 32'd559241, 32'h00123456,
                                   32'h00ffffff};

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        x_coord = '0;
        z_coord = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SEED;
        cfg_data = '0;
        error_count = 0;
        words_sent = 0;
        words_checked = 0;
        idle_cycles = 0;
        shadow_seed = SEED_RESET;
        shadow_count = COUNT_RESET;
        shadow_scale = SCALE_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset registers; zero scale maps everything to the origin
        foreach (directed[r])
            send_word(directed[r].x, directed[r].z, directed[r].has_value,
                      directed[r].value, r != directed.size() - 1);
        wait_drain();
        write_reg(REG_SCALE, 32'd0);
        send_word(32'h7fffffff, 32'h80000000, 1'b0, 16'd0, 1'b1);
        send_word(32'h00000000, 32'h00000000, 1'b0, 16'd0, 1'b0);
        wait_drain();
        // Unknown register index must leave the registers alone
        write_reg(2'd3, 32'hffffffff);
        write_reg(REG_SCALE, SCALE_RESET);

        for (int p = 0; p < 6; p++)
        begin
            wait_drain();
            write_reg(REG_SEED, seed_set[p]);
            write_reg(REG_COUNT, count_set[p]);
            write_reg(REG_SCALE, scale_set[p]);
            foreach (directed[r])
                if (r < 4)
                    send_word(directed[r].x, directed[r].z, 1'b0, 16'd0, r != 3);
            random_phase(RANDOM_WORDS / 6);
        end
        wait_drain();

        $display("Sent %0d coordinate words, checked %0d noise words over 8 register settings",
                 words_sent, words_checked);
        $display("Settings covered octave counts 0..15 saturation and scale extremes");
        if (error_count == 0 && expected_noise.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d words outstanding", error_count,
                     expected_noise.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
